// ===== src/rsld_pkg.sv =====
// Package for the response-strip length deframer.
// Holds the parse phase codes and the result beat type; no dependencies.
package rsld_pkg;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_VERSION  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ADDONLEN = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ADDON    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BODY     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LENLOW   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 3'd5;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } rsld_result_t;

endpackage

// ===== src/rsld_in_stage.sv =====
// Input register stage of the deframer.
// Captures one byte beat per cycle while its register is empty or being advanced; depends on nothing else.
module rsld_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    output logic       in_valid,
    output logic [7:0] in_byte,
    input  logic       advance
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign valid_next    = s_axis_tready ? s_axis_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            byte_reg <= s_axis_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== src/rsld_parser.sv =====
// Header strip and datagram parse state machine of the deframer.
// Uses rsld_pkg for phase codes and the result type.
module rsld_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 advance,
    input  logic [7:0]           in_byte,
    output logic                 emit,
    output rsld_pkg::rsld_result_t result
);
    import rsld_pkg::*;

    logic               mode_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [7:0]         addon_reg;
    logic [7:0]         addon_next;
    logic [7:0]         len_high_reg;
    logic [7:0]         len_high_next;
    logic [15:0]        payload_reg;
    logic [15:0]        payload_next;
    logic [15:0]        length_word;

    assign length_word = {len_high_reg, in_byte};

    always_comb begin
        phase_next    = phase_reg;
        addon_next    = addon_reg;
        len_high_next = len_high_reg;
        payload_next  = payload_reg;
        emit          = 1'b0;
        result        = '0;
        unique case (phase_reg)
            PH_ADDONLEN: begin
                addon_next = in_byte;
                phase_next = (in_byte == 8'd0) ? PH_BODY : PH_ADDON;
            end
            PH_ADDON: begin
                addon_next = addon_reg - 8'd1;
                if (addon_reg == 8'd1) begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY, PH_LENLOW, PH_PAYLOAD: begin
                if (!mode_reg) begin
                    phase_next   = PH_BODY;
                    payload_next = '0;
                    emit         = 1'b1;
                    result.data  = in_byte;
                end else if (phase_reg == PH_BODY) begin
                    len_high_next = in_byte;
                    phase_next    = PH_LENLOW;
                end else if (phase_reg == PH_LENLOW) begin
                    payload_next = length_word;
                    if (length_word == 16'd0) begin
                        phase_next   = PH_BODY;
                        emit         = 1'b1;
                        result.empty = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end else begin
                    payload_next = payload_reg - 16'd1;
                    emit         = 1'b1;
                    result.data  = in_byte;
                    if (payload_reg == 16'd1) begin
                        phase_next  = PH_BODY;
                        result.last = 1'b1;
                    end
                end
            end
            default: begin
                phase_next = PH_ADDONLEN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b0;
            phase_reg    <= PH_VERSION;
            addon_reg    <= '0;
            len_high_reg <= '0;
            payload_reg  <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (advance) begin
                phase_reg    <= phase_next;
                addon_reg    <= addon_next;
                len_high_reg <= len_high_next;
                payload_reg  <= payload_next;
            end
        end
    end

    a_reset_phase: assert property (@(posedge aclk)
        !aresetn |=> phase_reg == PH_VERSION)
        else $error("phase not at version after reset");

    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && result.empty |-> result.data == 8'd0 && !result.last)
        else $error("empty datagram marker carries data or last");

    a_stream_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !mode_reg |-> !result.last && !result.empty)
        else $error("stream mode beat flagged");

    a_version_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && phase_reg == PH_VERSION |=> phase_reg == PH_ADDONLEN)
        else $error("version byte did not advance to addon length");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit && result.last |=> phase_reg == PH_BODY && payload_reg == 16'd0)
        else $error("last payload byte did not close datagram");

endmodule

// ===== src/rsld_out_stage.sv =====
// Result register stage of the deframer.
// Holds one result beat until taken; uses rsld_pkg for the result type.
module rsld_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  emit,
    input  rsld_pkg::rsld_result_t result,
    output logic                  advance,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser
);
    import rsld_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    rsld_result_t result_reg;
    logic         load;

    assign load       = !valid_reg || m_axis_tready;
    assign advance    = in_valid && load;
    assign valid_next = load ? (in_valid && emit) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = result_reg.data;
    assign m_axis_tlast  = result_reg.last;
    assign m_axis_tuser  = result_reg.empty;

endmodule

// ===== src/response_strip_length_deframer.sv =====
// Response-strip length deframer top level: input register, parser, result register.
// A byte beat passes through the input register and then the result register before its result beat is valid.
// Throughput: one byte beat per cycle when the output does not stall; the parse state updates as each byte advances.
// Header and filler bytes produce no result beat, except a zero datagram length, which gives an empty marker beat.
// Reset (aresetn low, synchronous) empties both stages, clears the mode to stream
// and returns the parser to the version byte.
module response_strip_length_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast,   // datagram_last
    output logic       m_axis_tuser    // empty_datagram
);
    import rsld_pkg::*;

    logic         in_valid;
    logic [7:0]   in_byte;
    logic         advance;
    logic         emit;
    rsld_result_t result;

    rsld_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .in_valid      (in_valid),
        .in_byte       (in_byte),
        .advance       (advance)
    );

    rsld_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .in_byte   (in_byte),
        .emit      (emit),
        .result    (result)
    );

    rsld_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_valid),
        .emit          (emit),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
